FILE: sv/afs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_pkg
// Shared constants and types for the aspect-fit scaler setup block.
// ----------------------------------------------------------------------------
package afs_pkg;

   // screen registers and configuration port
   localparam int SCR_W            = 13;
   localparam int CSR_IDX_W        = 8;
   localparam int SRC_DIM_BITS_DEF = 13;

   localparam logic [SCR_W-1:0] SCREEN_W_RST = 13'd960;
   localparam logic [SCR_W-1:0] SCREEN_H_RST = 13'd544;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SCREEN_WIDTH  = 8'd0,
      REG_SCREEN_HEIGHT = 8'd1
   } reg_idx_type;

   // texture sizing: multiple of 16, at least 64, saturating in 25 bits
   localparam int TEX_W        = 25;
   localparam int TEX_ALIGN_SH = 4;
   localparam int TEX_HALF_SH  = 3;
   localparam int TEX_Q_W      = TEX_W - TEX_ALIGN_SH;
   localparam int TEX_Q_MAX    = 2097151;
   localparam logic [TEX_W-1:0] TEX_MIN = 25'd64;
   localparam logic [TEX_W-1:0] TEX_MAX = 25'd33554416;

   // result formats
   localparam int OFF_W    = 20;
   localparam int CROP_W   = 33;
   localparam int SCALE_W  = 32;
   localparam int POS_SH   = 8;
   localparam int SCALE_SH = 16;
   localparam int DIV2_Q_W = 32;
   localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h0001_0000;
   localparam logic [SCALE_W-1:0] SCALE_SAT = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [SCR_W-1:0] w;
      logic [SCR_W-1:0] h;
   } screen_type;

   typedef struct packed {
      logic zero;   // a source or screen dimension is zero
      logic fill;   // crop-to-fill mode
      logic eq;     // equal aspect
      logic adj_x;  // texture width is the adjusted dimension
   } flags_type;

endpackage

FILE: sv/afs_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_csr
// Screen size registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module afs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [afs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [afs_pkg::SCR_W-1:0]        csr_data,
   output afs_pkg::screen_type              screen
);

   afs_pkg::screen_type screen_ff;
   afs_pkg::screen_type screen_in;

   // always take a write; unknown indexes are dropped
   assign csr_ready = 1'b1;
   assign screen    = screen_ff;

   // decode the register index
   always_comb begin
      screen_in = screen_ff;
      if (csr_valid) begin
         case (csr_index)
            afs_pkg::REG_SCREEN_WIDTH:  screen_in.w = csr_data;
            afs_pkg::REG_SCREEN_HEIGHT: screen_in.h = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_ff.w <= afs_pkg::SCREEN_W_RST;
         screen_ff.h <= afs_pkg::SCREEN_H_RST;
      end else begin
         screen_ff <= screen_in;
      end
   end

endmodule

FILE: sv/afs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module afs_div #(
   parameter int NUM_W  = 8,
   parameter int DEN_W  = 8,
   parameter int QUO_W  = 8,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [NUM_W-1:0]  out_rem,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic              valid_ff [QUO_W];
   logic [NUM_W-1:0]  rem_ff   [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [QUO_W-1:0]  quo_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];

   genvar k;
   for (k = 0; k < QUO_W; k++) begin : g_stage
      logic              valid_prev;
      logic [NUM_W-1:0]  rem_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [QUO_W-1:0]  quo_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [CW-1:0]     rem_ext;
      logic [CW-1:0]     den_sh;
      logic [CW-1:0]     diff;
      logic              take;
      logic [NUM_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_num;
         assign den_prev   = in_den;
         assign quo_prev   = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // try to subtract the shifted divisor for this quotient bit
      always_comb begin
         rem_ext = CW'(rem_prev);
         den_sh  = CW'(den_prev) << (QUO_W - 1 - k);
         take    = (rem_ext >= den_sh);
         diff    = rem_ext - den_sh;
         rem_in  = take ? diff[NUM_W-1:0] : rem_prev;
         quo_in  = quo_prev;
         quo_in[QUO_W-1-k] = take;
      end

      // advance the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_prev;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_rem   = rem_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

FILE: sv/aspect_fit_scaler_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspect_fit_scaler_setup
// Texture size, placement, crop window and scale for a source picture.
// ----------------------------------------------------------------------------
// Takes one source size and fill mode per cycle while req_ready is high and
// returns one placement result per item, in order. The path is two front
// stages, a texture-size divider of SRC_DIM_BITS + 10 one-bit stages, three
// multiply/add stages, a 32-stage divider group that computes crop, offset
// and scale in parallel, and the output register.
// The output register holds a result until rsp_ready; while it is held the
// whole pipeline holds and req_ready is low. Screen size writes take effect
// for items accepted after the write.
module aspect_fit_scaler_setup #(
   parameter int SRC_DIM_BITS = afs_pkg::SRC_DIM_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [SRC_DIM_BITS-1:0]         req_src_width,
   input  logic [SRC_DIM_BITS-1:0]         req_src_height,
   input  logic                            req_fill_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_ok,
   output logic [afs_pkg::TEX_W-1:0]       rsp_tex_width,
   output logic [afs_pkg::TEX_W-1:0]       rsp_tex_height,
   output logic [afs_pkg::OFF_W-1:0]       rsp_dest_x_q8,
   output logic [afs_pkg::OFF_W-1:0]       rsp_dest_y_q8,
   output logic [afs_pkg::CROP_W-1:0]      rsp_crop_x_q8,
   output logic [afs_pkg::CROP_W-1:0]      rsp_crop_y_q8,
   output logic [afs_pkg::CROP_W-1:0]      rsp_crop_w_q8,
   output logic [afs_pkg::CROP_W-1:0]      rsp_crop_h_q8,
   output logic [afs_pkg::SCALE_W-1:0]     rsp_scale_x_q16,
   output logic [afs_pkg::SCALE_W-1:0]     rsp_scale_y_q16,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [afs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [afs_pkg::SCR_W-1:0]       csr_data
);

   localparam int S    = SRC_DIM_BITS;
   localparam int R    = afs_pkg::SCR_W;
   localparam int NW   = R + S;
   localparam int TW   = afs_pkg::TEX_W;
   localparam int QT   = NW - 3;
   localparam int QX   = (QT > afs_pkg::TEX_Q_W) ? QT : afs_pkg::TEX_Q_W;
   localparam int OL   = (NW + 1) / 2;
   localparam int OHW  = NW - OL;
   localparam int TOW  = TW + NW;
   localparam int CNW  = TOW + 7;
   localparam int DTW  = S + TW;
   localparam int SNW  = NW + afs_pkg::SCALE_SH + 2;
   localparam int SDW  = DTW + 1;
   localparam int Q2   = afs_pkg::DIV2_Q_W;
   localparam int SCW  = (SDW + Q2 > SNW) ? SDW + Q2 : SNW;
   localparam int ONW  = NW + afs_pkg::POS_SH + 1;
   localparam int ODW  = S + 1;
   localparam int D1NW = NW + 1;
   localparam int D1DW = S + afs_pkg::TEX_ALIGN_SH;
   localparam int FW   = $bits(afs_pkg::flags_type);
   localparam int SCRW = $bits(afs_pkg::screen_type);
   localparam int SD1W = FW + SCRW + NW + NW + S;
   localparam int SCRPW = FW + NW + TW;
   localparam int CRW  = afs_pkg::CROP_W;

   logic en;
   afs_pkg::screen_type screen;

   // ---------------------------------------------------------------- config
   afs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .screen    (screen)
   );

   // hold everything while a result waits at the output
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------------------------------------------- stage 1: products
   logic                s1_valid_ff;
   logic [NW-1:0]       s1_sp_ff, s1_pp_ff;
   logic [S-1:0]        s1_w_ff, s1_h_ff;
   logic                s1_fill_ff, s1_zero_ff;
   afs_pkg::screen_type s1_scr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
      if (en) begin
         s1_sp_ff   <= NW'(screen.w) * NW'(req_src_height);
         s1_pp_ff   <= NW'(screen.h) * NW'(req_src_width);
         s1_w_ff    <= req_src_width;
         s1_h_ff    <= req_src_height;
         s1_fill_ff <= req_fill_mode;
         s1_scr_ff  <= screen;
         s1_zero_ff <= (req_src_width == '0) || (req_src_height == '0) ||
                       (screen.w == '0) || (screen.h == '0);
      end
   end

   // ---------------------------------------- stage 2: aspect and axis pick
   logic                s1_gt, s1_lt;
   afs_pkg::flags_type  s2_flags_in;
   logic [NW-1:0]       s2_n_in, s2_o_in;
   logic [S-1:0]        s2_d_in;

   always_comb begin
      s1_gt             = s1_sp_ff > s1_pp_ff;
      s1_lt             = s1_sp_ff < s1_pp_ff;
      s2_flags_in.zero  = s1_zero_ff;
      s2_flags_in.fill  = s1_fill_ff;
      s2_flags_in.eq    = !s1_gt && !s1_lt;
      s2_flags_in.adj_x = s1_fill_ff ? s1_lt : s1_gt;
      s2_n_in = s2_flags_in.adj_x ? s1_pp_ff : s1_sp_ff;
      s2_o_in = s2_flags_in.adj_x ? s1_sp_ff : s1_pp_ff;
      s2_d_in = s2_flags_in.adj_x ? s1_h_ff : s1_w_ff;
   end

   logic                s2_valid_ff;
   afs_pkg::flags_type  s2_flags_ff;
   afs_pkg::screen_type s2_scr_ff;
   logic [NW-1:0]       s2_n_ff, s2_o_ff;
   logic [S-1:0]        s2_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_flags_ff <= s2_flags_in;
         s2_scr_ff   <= s1_scr_ff;
         s2_n_ff     <= s2_n_in;
         s2_o_ff     <= s2_o_in;
         s2_d_ff     <= s2_d_in;
      end
   end

   // -------------------------------- texture divider: (N + 8D) / (16D)
   logic [D1NW-1:0]     d1_num;
   logic [D1DW-1:0]     d1_den;
   logic                d1_valid;
   logic [QT-1:0]       d1_quo;
   logic [D1NW-1:0]     d1_rem;
   logic [SD1W-1:0]     d1_side;
   afs_pkg::flags_type  d1_flags;
   afs_pkg::screen_type d1_scr;
   logic [NW-1:0]       d1_n, d1_o;
   logic [S-1:0]        d1_d;

   assign d1_num = D1NW'(s2_n_ff) + (D1NW'(s2_d_ff) << afs_pkg::TEX_HALF_SH);
   assign d1_den = D1DW'(s2_d_ff) << afs_pkg::TEX_ALIGN_SH;

   afs_div #(
      .NUM_W  (D1NW),
      .DEN_W  (D1DW),
      .QUO_W  (QT),
      .SIDE_W (SD1W)
   ) u_div_tex (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .in_num    (d1_num),
      .in_den    (d1_den),
      .in_side   ({s2_flags_ff, s2_scr_ff, s2_n_ff, s2_o_ff, s2_d_ff}),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_rem   (d1_rem),
      .out_side  (d1_side)
   );

   assign {d1_flags, d1_scr, d1_n, d1_o, d1_d} = d1_side;

   // ------------------------------- stage 3: align, clamp and saturate
   logic [QX-1:0] s3_qx;
   logic [TW-1:0] s3_al;
   logic [TW-1:0] s3_t_in;
   logic          s3_rem_unused;

   always_comb begin
      s3_qx   = QX'(d1_quo);
      s3_al   = {s3_qx[afs_pkg::TEX_Q_W-1:0], {afs_pkg::TEX_ALIGN_SH{1'b0}}};
      s3_t_in = (s3_qx > QX'(afs_pkg::TEX_Q_MAX)) ? afs_pkg::TEX_MAX :
                (s3_al < afs_pkg::TEX_MIN) ? afs_pkg::TEX_MIN : s3_al;
      // the texture quotient needs no remainder
      s3_rem_unused = ^d1_rem;
   end

   logic                s3_valid_ff;
   afs_pkg::flags_type  s3_flags_ff;
   afs_pkg::screen_type s3_scr_ff;
   logic [NW-1:0]       s3_n_ff, s3_o_ff;
   logic [S-1:0]        s3_d_ff;
   logic [TW-1:0]       s3_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= d1_valid && (s3_rem_unused || !s3_rem_unused);
      end
      if (en) begin
         s3_flags_ff <= d1_flags;
         s3_scr_ff   <= d1_scr;
         s3_n_ff     <= d1_n;
         s3_o_ff     <= d1_o;
         s3_d_ff     <= d1_d;
         s3_t_ff     <= s3_t_in;
      end
   end

   // --------------------------------------- stage 4: partial products
   logic                s4_valid_ff;
   afs_pkg::flags_type  s4_flags_ff;
   afs_pkg::screen_type s4_scr_ff;
   logic [NW-1:0]       s4_n_ff;
   logic [S-1:0]        s4_d_ff;
   logic [TW-1:0]       s4_t_ff;
   logic [TW+OL-1:0]    s4_lo_ff;
   logic [TW+OHW-1:0]   s4_hi_ff;
   logic [DTW-1:0]      s4_dt_ff;
   logic [ONW-1:0]      s4_off_num_ff;
   logic [NW-1:0]       s4_diff;

   assign s4_diff = s3_o_ff - s3_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (en) begin
         s4_flags_ff   <= s3_flags_ff;
         s4_scr_ff     <= s3_scr_ff;
         s4_n_ff       <= s3_n_ff;
         s4_d_ff       <= s3_d_ff;
         s4_t_ff       <= s3_t_ff;
         s4_lo_ff      <= (TW+OL)'(s3_t_ff) * (TW+OL)'(s3_o_ff[OL-1:0]);
         s4_hi_ff      <= (TW+OHW)'(s3_t_ff) * (TW+OHW)'(s3_o_ff[NW-1:OL]);
         s4_dt_ff      <= DTW'(s3_d_ff) * DTW'(s3_t_ff);
         s4_off_num_ff <= (ONW'(s4_diff) << afs_pkg::POS_SH) + ONW'(s3_d_ff);
      end
   end

   // --------------------------- stage 5: product sum, scale operands
   logic [SNW-1:0] s5_snum_in;
   logic [SDW-1:0] s5_sden_in;
   logic           s5_sat_in;

   always_comb begin
      s5_snum_in = (SNW'(s4_n_ff) << (afs_pkg::SCALE_SH + 1)) + SNW'(s4_dt_ff);
      s5_sden_in = SDW'(s4_dt_ff) << 1;
      s5_sat_in  = SCW'(s5_snum_in) >= (SCW'(s5_sden_in) << Q2);
   end

   logic                s5_valid_ff;
   afs_pkg::flags_type  s5_flags_ff;
   afs_pkg::screen_type s5_scr_ff;
   logic [NW-1:0]       s5_n_ff;
   logic [TW-1:0]       s5_t_ff;
   logic [TOW-1:0]      s5_to_ff;
   logic [SNW-1:0]      s5_snum_ff;
   logic [SDW-1:0]      s5_sden_ff;
   logic                s5_sat_ff;
   logic [ONW-1:0]      s5_off_num_ff;
   logic [ODW-1:0]      s5_off_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (en) begin
         s5_flags_ff   <= s4_flags_ff;
         s5_scr_ff     <= s4_scr_ff;
         s5_n_ff       <= s4_n_ff;
         s5_t_ff       <= s4_t_ff;
         s5_to_ff      <= TOW'(s4_lo_ff) + (TOW'(s4_hi_ff) << OL);
         s5_snum_ff    <= s5_snum_in;
         s5_sden_ff    <= s5_sden_in;
         s5_sat_ff     <= s5_sat_in;
         s5_off_num_ff <= s4_off_num_ff;
         s5_off_den_ff <= ODW'(s4_d_ff) << 1;
      end
   end

   // ----------------------------- divider group: crop, scale, offset
   logic                cd_valid;
   logic [Q2-1:0]       cd_quo;
   logic [CNW-1:0]      cd_rem;
   logic [SCRPW-1:0]    cd_side;
   afs_pkg::flags_type  f_flags;
   logic [NW-1:0]       f_n;
   logic [TW-1:0]       f_t;

   afs_div #(
      .NUM_W  (CNW),
      .DEN_W  (NW),
      .QUO_W  (Q2),
      .SIDE_W (SCRPW)
   ) u_div_crop (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_valid_ff),
      .in_num    (CNW'(s5_to_ff) << 7),
      .in_den    (s5_n_ff),
      .in_side   ({s5_flags_ff, s5_n_ff, s5_t_ff}),
      .out_valid (cd_valid),
      .out_quo   (cd_quo),
      .out_rem   (cd_rem),
      .out_side  (cd_side)
   );

   assign {f_flags, f_n, f_t} = cd_side;

   logic [Q2-1:0] sd_quo;
   logic          f_sat;

   afs_div #(
      .NUM_W  (SNW),
      .DEN_W  (SDW),
      .QUO_W  (Q2),
      .SIDE_W (1)
   ) u_div_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_valid_ff),
      .in_num    (s5_snum_ff),
      .in_den    (s5_sden_ff),
      .in_side   (s5_sat_ff),
      .out_valid (),
      .out_quo   (sd_quo),
      .out_rem   (),
      .out_side  (f_sat)
   );

   logic [Q2-1:0]       od_quo;
   afs_pkg::screen_type f_scr;

   afs_div #(
      .NUM_W  (ONW),
      .DEN_W  (ODW),
      .QUO_W  (Q2),
      .SIDE_W (SCRW)
   ) u_div_off (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_valid_ff),
      .in_num    (s5_off_num_ff),
      .in_den    (s5_off_den_ff),
      .in_side   (s5_scr_ff),
      .out_valid (),
      .out_quo   (od_quo),
      .out_rem   (),
      .out_side  (f_scr)
   );

   // --------------------------------------------- assemble the result
   logic [NW-1:0]                  f_rem;
   logic [NW+1:0]                  f_r4, f_n1, f_n3;
   logic [1:0]                     f_round;
   logic                           f_up;
   logic [CRW-1:0]                 f_len, f_off;
   logic [afs_pkg::SCALE_W-1:0]    f_scale;
   logic                           f_empty;
   logic                           ok_in;
   logic [TW-1:0]                  tex_w_in, tex_h_in;
   logic [afs_pkg::OFF_W-1:0]      dest_x_in, dest_y_in;
   logic [CRW-1:0]                 crop_x_in, crop_y_in, crop_w_in, crop_h_in;
   logic [afs_pkg::SCALE_W-1:0]    scale_x_in, scale_y_in;

   always_comb begin
      // round the window from quotient and remainder of 128*t*O / N
      f_rem   = cd_rem[NW-1:0];
      f_r4    = (NW+2)'(f_rem) << 2;
      f_n1    = (NW+2)'(f_n);
      f_n3    = f_n1 + (f_n1 << 1);
      f_round = (f_r4 < f_n1) ? 2'd0 : ((f_r4 < f_n3) ? 2'd1 : 2'd2);
      f_up    = ((NW+1)'(f_rem) << 1) > (NW+1)'(f_n);
      f_len   = (CRW'(cd_quo) << 1) + CRW'(f_round);
      f_off   = (CRW'(f_t) << 7) - CRW'(cd_quo) - CRW'(f_up);
      f_scale = f_sat ? afs_pkg::SCALE_SAT : sd_quo[afs_pkg::SCALE_W-1:0];
      f_empty = f_flags.fill && !f_flags.eq && (f_len == '0);

      ok_in      = 1'b0;
      tex_w_in   = '0;
      tex_h_in   = '0;
      dest_x_in  = '0;
      dest_y_in  = '0;
      crop_x_in  = '0;
      crop_y_in  = '0;
      crop_w_in  = '0;
      crop_h_in  = '0;
      scale_x_in = '0;
      scale_y_in = '0;

      if (!f_flags.zero && !f_empty) begin
         // start from the screen-sized texture shown whole
         ok_in      = 1'b1;
         tex_w_in   = TW'(f_scr.w);
         tex_h_in   = TW'(f_scr.h);
         crop_w_in  = CRW'(f_scr.w) << afs_pkg::POS_SH;
         crop_h_in  = CRW'(f_scr.h) << afs_pkg::POS_SH;
         scale_x_in = afs_pkg::SCALE_ONE;
         scale_y_in = afs_pkg::SCALE_ONE;
         if (!f_flags.eq) begin
            if (f_flags.adj_x) begin
               tex_w_in   = f_t;
               scale_x_in = f_scale;
               if (f_flags.fill) begin
                  crop_w_in = f_len;
                  crop_x_in = f_off;
               end else begin
                  crop_w_in = CRW'(f_t) << afs_pkg::POS_SH;
                  dest_x_in = od_quo[afs_pkg::OFF_W-1:0];
               end
            end else begin
               tex_h_in   = f_t;
               scale_y_in = f_scale;
               if (f_flags.fill) begin
                  crop_h_in = f_len;
                  crop_y_in = f_off;
               end else begin
                  crop_h_in = CRW'(f_t) << afs_pkg::POS_SH;
                  dest_y_in = od_quo[afs_pkg::OFF_W-1:0];
               end
            end
         end
      end
   end

   // ------------------------------------------------ output register
   logic                         rsp_ok_ff;
   logic [TW-1:0]                rsp_tex_w_ff, rsp_tex_h_ff;
   logic [afs_pkg::OFF_W-1:0]    rsp_dest_x_ff, rsp_dest_y_ff;
   logic [CRW-1:0]               rsp_crop_x_ff, rsp_crop_y_ff;
   logic [CRW-1:0]               rsp_crop_w_ff, rsp_crop_h_ff;
   logic [afs_pkg::SCALE_W-1:0]  rsp_scale_x_ff, rsp_scale_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cd_valid;
      end
      if (en) begin
         rsp_ok_ff      <= ok_in;
         rsp_tex_w_ff   <= tex_w_in;
         rsp_tex_h_ff   <= tex_h_in;
         rsp_dest_x_ff  <= dest_x_in;
         rsp_dest_y_ff  <= dest_y_in;
         rsp_crop_x_ff  <= crop_x_in;
         rsp_crop_y_ff  <= crop_y_in;
         rsp_crop_w_ff  <= crop_w_in;
         rsp_crop_h_ff  <= crop_h_in;
         rsp_scale_x_ff <= scale_x_in;
         rsp_scale_y_ff <= scale_y_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_tex_width   = rsp_tex_w_ff;
   assign rsp_tex_height  = rsp_tex_h_ff;
   assign rsp_dest_x_q8   = rsp_dest_x_ff;
   assign rsp_dest_y_q8   = rsp_dest_y_ff;
   assign rsp_crop_x_q8   = rsp_crop_x_ff;
   assign rsp_crop_y_q8   = rsp_crop_y_ff;
   assign rsp_crop_w_q8   = rsp_crop_w_ff;
   assign rsp_crop_h_q8   = rsp_crop_h_ff;
   assign rsp_scale_x_q16 = rsp_scale_x_ff;
   assign rsp_scale_y_q16 = rsp_scale_y_ff;

endmodule

FILE: sim/tb_aspect_fit_scaler_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aspect_fit_scaler_setup
// Self-checking bench for the aspect-fit scaler setup block.
// ----------------------------------------------------------------------------
// Drives source sizes and fill modes under several screen sizes, predicts
// each placement result in 64-bit integer arithmetic and checks every
// result transfer against the oldest prediction. Both channels idle at
// random; screen writes happen only while the block is drained.
// ----------------------------------------------------------------------------
module tb_aspect_fit_scaler_setup;

   localparam int  DIM_W       = afs_pkg::SRC_DIM_BITS_DEF;
   localparam int  SCR_BITS    = afs_pkg::SCR_W;
   localparam int  STALL_LIMIT = 4000;
   localparam int  DRAIN_WAIT  = 80;
   localparam logic [afs_pkg::CSR_IDX_W-1:0] IDX_SPARE_LO = 8'd2;
   localparam logic [afs_pkg::CSR_IDX_W-1:0] IDX_SPARE_HI = 8'hFF;

   typedef struct packed {
      logic                         ok;
      logic [afs_pkg::TEX_W-1:0]    tex_w;
      logic [afs_pkg::TEX_W-1:0]    tex_h;
      logic [afs_pkg::OFF_W-1:0]    dest_x;
      logic [afs_pkg::OFF_W-1:0]    dest_y;
      logic [afs_pkg::CROP_W-1:0]   crop_x;
      logic [afs_pkg::CROP_W-1:0]   crop_y;
      logic [afs_pkg::CROP_W-1:0]   crop_w;
      logic [afs_pkg::CROP_W-1:0]   crop_h;
      logic [afs_pkg::SCALE_W-1:0]  scale_x;
      logic [afs_pkg::SCALE_W-1:0]  scale_y;
   } placement_type;

   typedef bit [63:0] u64_type;

   // Placement predictor and store of expected placements
   class placement_board;
      u64_type         scr_w;
      u64_type         scr_h;
      placement_type   expected_q[$];
      int              mismatches;

      function new();
         scr_w = u64_type'(afs_pkg::SCREEN_W_RST);
         scr_h = u64_type'(afs_pkg::SCREEN_H_RST);
         mismatches = 0;
      endfunction

      function void write_screen(logic [afs_pkg::CSR_IDX_W-1:0] idx,
                                 logic [afs_pkg::SCR_W-1:0] val);
         if (idx == afs_pkg::REG_SCREEN_WIDTH) scr_w = u64_type'(val);
         else if (idx == afs_pkg::REG_SCREEN_HEIGHT) scr_h = u64_type'(val);
      endfunction

      function u64_type round_div(u64_type n, u64_type d);
         if (d == 0) return 0;
         return (2 * n + d) / (2 * d);
      endfunction

      function u64_type align_dim(u64_type n, u64_type d);
         u64_type q;
         if (d == 0) return u64_type'(afs_pkg::TEX_MIN);
         q = (n + 8 * d) / (16 * d);
         if (q > u64_type'(afs_pkg::TEX_Q_MAX)) return u64_type'(afs_pkg::TEX_MAX);
         q = q * 16;
         return (q < u64_type'(afs_pkg::TEX_MIN)) ? u64_type'(afs_pkg::TEX_MIN) : q;
      endfunction

      function void note_request(u64_type w, u64_type h, bit fill);
         placement_type p;
         u64_type sp, pp, tw, th, dx, dy, cx, cy, cw, ch, sx, sy;
         u64_type nw, dw, nh, dh;
         p = '0;
         dx = 0; dy = 0; cx = 0; cy = 0;
         if (w == 0 || h == 0 || scr_w == 0 || scr_h == 0) begin
            expected_q.push_back(p);
            return;
         end
         sp = scr_w * h;
         pp = scr_h * w;
         tw = scr_w;
         th = scr_h;
         if (sp > pp) begin
            if (fill) th = align_dim(scr_w * h, w);
            else tw = align_dim(scr_h * w, h);
         end else if (sp < pp) begin
            if (fill) tw = align_dim(scr_h * w, h);
            else th = align_dim(scr_w * h, w);
         end
         if (!fill) begin
            // letterbox: shown size nw/dw by nh/dh
            if (sp > pp) begin
               nw = scr_h * w; dw = h; nh = scr_h; dh = 1;
            end else begin
               nw = scr_w; dw = 1; nh = scr_w * h; dh = w;
            end
            dx = round_div(128 * (scr_w * dw - nw), dw);
            dy = round_div(128 * (scr_h * dh - nh), dh);
            cw = tw << 8;
            ch = th << 8;
            sx = round_div(65536 * nw, dw * tw);
            sy = round_div(65536 * nh, dh * th);
         end else begin
            // crop: window nw/dw by nh/dh inside the texture
            if (sp >= pp) begin
               nw = tw; dw = 1; nh = scr_h * w * th; dh = scr_w * h;
            end else begin
               nw = scr_w * h * tw; dw = scr_h * w; nh = th; dh = 1;
            end
            if (nw > tw * dw) nw = tw * dw;
            if (nh > th * dh) nh = th * dh;
            cw = round_div(256 * nw, dw);
            ch = round_div(256 * nh, dh);
            if (cw == 0 || ch == 0) begin
               expected_q.push_back(p);
               return;
            end
            cx = round_div(128 * (tw * dw - nw), dw);
            cy = round_div(128 * (th * dh - nh), dh);
            sx = round_div(65536 * scr_w * dw, nw);
            sy = round_div(65536 * scr_h * dh, nh);
         end
         if (sx > 64'hFFFF_FFFF) sx = u64_type'(afs_pkg::SCALE_SAT);
         if (sy > 64'hFFFF_FFFF) sy = u64_type'(afs_pkg::SCALE_SAT);
         p.ok = 1'b1;
         p.tex_w = tw[afs_pkg::TEX_W-1:0];
         p.tex_h = th[afs_pkg::TEX_W-1:0];
         p.dest_x = dx[afs_pkg::OFF_W-1:0];
         p.dest_y = dy[afs_pkg::OFF_W-1:0];
         p.crop_x = cx[afs_pkg::CROP_W-1:0];
         p.crop_y = cy[afs_pkg::CROP_W-1:0];
         p.crop_w = cw[afs_pkg::CROP_W-1:0];
         p.crop_h = ch[afs_pkg::CROP_W-1:0];
         p.scale_x = sx[afs_pkg::SCALE_W-1:0];
         p.scale_y = sy[afs_pkg::SCALE_W-1:0];
         expected_q.push_back(p);
      endfunction

      function void check_result(placement_type got);
         placement_type exp_p;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         exp_p = expected_q.pop_front();
         if (got !== exp_p) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", exp_p, got);
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [DIM_W-1:0]               req_src_width = '0;
   logic [DIM_W-1:0]               req_src_height = '0;
   logic                           req_fill_mode = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   placement_type                  rsp;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [afs_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [afs_pkg::SCR_W-1:0]      csr_data = '0;

   placement_board board = new();
   bit             no_idle = 1'b0;
   int             stall_cycles = 0;

   always #5 clock = ~clock;

   aspect_fit_scaler_setup u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_src_width(req_src_width), .req_src_height(req_src_height),
      .req_fill_mode(req_fill_mode),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_ok(rsp.ok), .rsp_tex_width(rsp.tex_w), .rsp_tex_height(rsp.tex_h),
      .rsp_dest_x_q8(rsp.dest_x), .rsp_dest_y_q8(rsp.dest_y),
      .rsp_crop_x_q8(rsp.crop_x), .rsp_crop_y_q8(rsp.crop_y),
      .rsp_crop_w_q8(rsp.crop_w), .rsp_crop_h_q8(rsp.crop_h),
      .rsp_scale_x_q16(rsp.scale_x), .rsp_scale_y_q16(rsp.scale_y),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : (no_idle || $urandom_range(99) >= 10);
   end

   // Track every transfer; count cycles without one
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_screen(csr_index, csr_data);
         if (req_valid && req_ready)
            board.note_request(u64_type'(req_src_width), u64_type'(req_src_height),
                               req_fill_mode);
         if (rsp_valid && rsp_ready) board.check_result(rsp);
         if ((csr_valid && csr_ready) || (req_valid && req_ready) ||
             (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic fill);
      int gap;
      gap = (!no_idle && $urandom_range(99) < 10) ? 1 : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_src_width <= w;
      req_src_height <= h;
      req_fill_mode <= fill;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drain the pipeline, then write one register
   task automatic write_screen_reg(input logic [afs_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [afs_pkg::SCR_W-1:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_screen(input logic [afs_pkg::SCR_W-1:0] w,
                             input logic [afs_pkg::SCR_W-1:0] h);
      write_screen_reg(afs_pkg::REG_SCREEN_WIDTH, w);
      write_screen_reg(afs_pkg::REG_SCREEN_HEIGHT, h);
   endtask

   // Mostly plausible video sizes, some extremes and zeros
   task automatic random_sizes(input int count);
      logic [DIM_W-1:0] w, h;
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         if (sel < 60) begin
            w = DIM_W'($urandom_range(16, 4096));
            h = DIM_W'($urandom_range(16, 4096));
         end else if (sel < 85) begin
            w = DIM_W'($urandom);
            h = DIM_W'($urandom);
         end else if (sel < 95) begin
            w = DIM_W'($urandom_range(1, 8));
            h = DIM_W'($urandom_range(4000, 8191));
            if ($urandom_range(1) != 0) begin
               w = h;
               h = DIM_W'($urandom_range(1, 8));
            end
         end else begin
            w = ($urandom_range(1) != 0) ? '0 : DIM_W'($urandom);
            h = (w == '0) ? DIM_W'($urandom) : '0;
         end
         send_size(w, h, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, both modes, equal aspect, zeros, empty windows
      for (int m = 0; m < 2; m++) begin
         send_size(13'd960, 13'd544, 1'(m));
         send_size(13'd1920, 13'd1080, 1'(m));
         send_size(13'd640, 13'd480, 1'(m));
         send_size(13'd1, 13'd1, 1'(m));
         send_size(13'd8191, 13'd8191, 1'(m));
         send_size(13'd8191, 13'd1, 1'(m));
         send_size(13'd1, 13'd8191, 1'(m));
         send_size(13'd0, 13'd100, 1'(m));
         send_size(13'd100, 13'd0, 1'(m));
         send_size(13'h1555, 13'h0AAA, 1'(m));
         send_size(13'h0AAA, 13'h1555, 1'(m));
      end
      random_sizes(250);

      set_screen(13'd16, 13'd16);
      send_size(13'd8191, 13'd1, 1'b0);
      send_size(13'd1, 13'd8191, 1'b1);
      random_sizes(200);

      set_screen(13'd4096, 13'd4096);
      random_sizes(200);

      // spare indexes must leave the screen untouched
      write_screen_reg(IDX_SPARE_LO, 13'd100);
      write_screen_reg(IDX_SPARE_HI, 13'h1FFF);
      set_screen(13'h1FFF, 13'd16);
      no_idle = 1'b1;
      random_sizes(300);
      no_idle = 1'b0;

      set_screen(13'd0, 13'd544);
      random_sizes(40);
      set_screen(13'd960, 13'd0);
      random_sizes(40);

      set_screen(SCR_BITS'($urandom_range(16, 4096)), SCR_BITS'($urandom_range(16, 4096)));
      random_sizes(250);
      set_screen(13'd1280, 13'd720);
      random_sizes(250);

      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
sv/afs_pkg.sv
sv/afs_csr.sv
sv/afs_div.sv
sv/aspect_fit_scaler_setup.sv
sim/tb_aspect_fit_scaler_setup.sv
